>>> design/cfa_pkg.sv
package cfa_pkg;

    // Field widths fixed by the request and response formats.
    localparam int FRAME_W = 20;
    localparam int CNT_W   = 11;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Default map depth.
    localparam int MAX_FRAMES_DEF = 1024;

    // Saturation limit of the free frame counter.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request codes.
    localparam logic [1:0] REQ_INIT    = 2'd0;
    localparam logic [1:0] REQ_ALLOC   = 2'd1;
    localparam logic [1:0] REQ_MARK    = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    // Response status codes.
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_NOFIT    = 2'd1;
    localparam logic [1:0] RS_NOT_HEAD = 2'd2;
    localparam logic [1:0] RS_RANGE    = 2'd3;

    // Per-frame state codes.
    localparam logic [1:0] FS_FREE  = 2'd0;
    localparam logic [1:0] FS_HEAD  = 2'd1;
    localparam logic [1:0] FS_ALLOC = 2'd2;

    // Register indexes (word address bits [3:2]).
    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_POOL = 2'd1;
    localparam logic [1:0] REG_INFO = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FRAME_W-1:0] frame_no;
        logic [CNT_W-1:0]   count;
    } cfa_req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] first_frame;
        logic [1:0]         status;
        logic [CNT_W-1:0]   free_frames;
    } cfa_rsp_t;

endpackage

>>> design/contiguous_frame_allocator_unit.sv
// First-fit contiguous frame allocator. A map of MAX_FRAMES two-bit frame
// states lives in a single-port-write, single-port-read memory, and one small
// sequencer walks it one entry per cycle with a shared pointer and compare.
// One request is worked at a time and the request side stalls meanwhile.
// Init sweeps the whole map; allocate runs a first-fit scan, then the claim
// writes; mark overwrites the given run; release walks the freed run up to its
// end or the last frame of the pool, and a release of a frame that is not a
// head stops at that frame; requests rejected up front go straight to the
// result. After reset the block sweeps the map clear before it takes its first
// request; configuration writes are taken during that pass. A finished result
// sits in an output register until the response side takes it.
module contiguous_frame_allocator_unit
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  cfa_req_t           req,
    // Response channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cfa_rsp_t           rsp,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_FRAMES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_CLAIM,
        S_MARK,
        S_REL,
        S_DONE
    } state_t;

    // Frame state map.
    logic [1:0] map_mem [MAX_FRAMES];
    logic [1:0] rdata_reg;
    logic       mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0] mem_wdata;

    // Configuration registers.
    logic [FRAME_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]   pool_reg, pool_next;
    logic [FRAME_W-1:0] info_reg, info_next;

    // Sequencer state.
    state_t             state_reg, state_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               pend_reg, pend_next;
    logic               first_reg, first_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   fc_reg, fc_next;
    logic               head_en_reg, head_en_next;
    logic [AW-1:0]      head_idx_reg, head_idx_next;
    logic [1:0]         status_reg, status_next;
    logic [FRAME_W-1:0] ff_reg, ff_next;
    logic               rsp_valid_reg, rsp_valid_next;
    cfa_rsp_t           rsp_reg, rsp_next;

    // Derived values.
    logic [CW-1:0]      n;
    logic [FRAME_W:0]   off_full;
    logic [FRAME_W-1:0] off;
    logic               below;
    logic [FRAME_W-1:0] abs_info;
    logic [FRAME_W:0]   info_full;
    logic               info_in;
    logic               cfg_wr;
    logic [CNT_W-1:0]   fc_dec;
    logic [CNT_W-1:0]   fc_inc;
    logic [CW-1:0]      claim_start;

    assign pready    = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_wr    = psel && penable && pwrite;

    // Register readback.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE: prdata = PDATA_W'(base_reg);
            REG_POOL: prdata = PDATA_W'(pool_reg);
            REG_INFO: prdata = PDATA_W'(info_reg);
            default:  prdata = '0;
        endcase
    end

    // Pool size, request offset and info frame placement.
    always_comb
    begin
        n         = (32'(pool_reg) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(pool_reg);
        off_full  = {1'b0, req.frame_no} - {1'b0, base_reg};
        below     = off_full[FRAME_W];
        off       = off_full[FRAME_W-1:0];
        abs_info  = (info_reg == '0) ? base_reg : info_reg;
        info_full = {1'b0, abs_info} - {1'b0, base_reg};
        info_in   = !info_full[FRAME_W] && (32'(info_full[FRAME_W-1:0]) < 32'(n));
        fc_dec    = (fc_reg == '0) ? fc_reg : fc_reg - 1'b1;
        fc_inc    = (fc_reg == CNT_MAX) ? fc_reg : fc_reg + 1'b1;
        claim_start = ptr_reg - CW'(rem_reg);
    end

    // Sequencer next-state logic.
    always_comb
    begin
        base_next      = base_reg;
        pool_next      = pool_reg;
        info_next      = info_reg;
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        rem_next       = rem_reg;
        run_next       = run_reg;
        fc_next        = fc_reg;
        head_en_next   = head_en_reg;
        head_idx_next  = head_idx_reg;
        status_next    = status_reg;
        ff_next        = ff_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        // Configuration writes.
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BASE: base_next = pwdata[FRAME_W-1:0];
                REG_POOL: pool_next = pwdata[CNT_W-1:0];
                REG_INFO: info_next = pwdata[FRAME_W-1:0];
                default:  ;
            endcase
        end

        // Response transfer frees the output register.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    pend_next   = 1'b0;
                    first_next  = 1'b1;
                    status_next = RS_OK;
                    ff_next     = '0;
                    rem_next    = req.count;
                    run_next    = '0;
                    ptr_next    = '0;
                    unique case (req.req_type)
                        REQ_INIT:
                        begin
                            head_en_next  = info_in;
                            head_idx_next = AW'(info_full[FRAME_W-1:0]);
                            fc_next       = CNT_W'(n) - CNT_W'(info_in);
                            state_next    = S_INIT;
                        end
                        REQ_ALLOC:
                        begin
                            if (req.count == '0 || 32'(req.count) > 32'(n))
                            begin
                                status_next = RS_NOFIT;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_MARK:
                        begin
                            if (req.count == '0)
                            begin
                                status_next = RS_NOFIT;
                                state_next  = S_DONE;
                            end
                            else if (below || 32'(off) > 32'(n) ||
                                     32'(req.count) + 32'(off) > 32'(n))
                            begin
                                status_next = RS_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = CW'(off);
                                state_next = S_MARK;
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (below || 32'(off) >= 32'(n))
                            begin
                                status_next = RS_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = CW'(off);
                                state_next = S_REL;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_INIT:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = S_DONE;
                end
            end

            // First-fit scan: read one entry per cycle, check the previous one.
            S_SCAN:
            begin
                ptr_next  = ptr_reg + 1'b1;
                pos_next  = ptr_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (rdata_reg == FS_FREE && run_reg + 1'b1 == rem_reg)
                    begin
                        ptr_next   = claim_start;
                        ff_next    = base_reg + FRAME_W'(claim_start);
                        first_next = 1'b1;
                        state_next = S_CLAIM;
                    end
                    else
                    begin
                        run_next = (rdata_reg == FS_FREE) ? run_reg + 1'b1 : '0;
                        if (ptr_reg == n)
                        begin
                            status_next = RS_NOFIT;
                            state_next  = S_DONE;
                        end
                    end
                end
            end

            // Claim the run found by the scan.
            S_CLAIM:
            begin
                ptr_next   = ptr_reg + 1'b1;
                first_next = 1'b0;
                rem_next   = rem_reg - 1'b1;
                fc_next    = fc_dec;
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end

            // Mark: read ahead, overwrite the entry read in the cycle before.
            S_MARK:
            begin
                ptr_next  = ptr_reg + 1'b1;
                pos_next  = ptr_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    first_next = 1'b0;
                    rem_next   = rem_reg - 1'b1;
                    if (rdata_reg == FS_FREE)
                    begin
                        fc_next = fc_dec;
                    end
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // Release: free the head, then the allocated frames behind it.
            S_REL:
            begin
                ptr_next  = ptr_reg + 1'b1;
                pos_next  = ptr_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        if (rdata_reg != FS_HEAD)
                        begin
                            status_next = RS_NOT_HEAD;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            fc_next    = fc_inc;
                            first_next = 1'b0;
                            if (ptr_reg == n)
                            begin
                                state_next = S_DONE;
                            end
                        end
                    end
                    else if (rdata_reg == FS_FREE || rdata_reg == FS_HEAD)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                        if (ptr_reg == n)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.first_frame = ff_reg;
                    rsp_next.status      = status_reg;
                    rsp_next.free_frames = fc_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Map write port.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[AW-1:0];
        mem_wdata = FS_FREE;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_INIT:
            begin
                mem_we = 1'b1;
                if (head_en_reg && ptr_reg[AW-1:0] == head_idx_reg)
                begin
                    mem_wdata = FS_HEAD;
                end
            end
            S_CLAIM:
            begin
                mem_we    = 1'b1;
                mem_wdata = first_reg ? FS_HEAD : FS_ALLOC;
            end
            S_MARK:
            begin
                mem_we    = pend_reg;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = first_reg ? FS_HEAD : FS_ALLOC;
            end
            S_REL:
            begin
                mem_waddr = pos_reg[AW-1:0];
                if (first_reg)
                begin
                    mem_we = pend_reg && (rdata_reg == FS_HEAD);
                end
                else
                begin
                    mem_we = pend_reg && (rdata_reg != FS_FREE) && (rdata_reg != FS_HEAD);
                end
            end
            default: ;
        endcase
    end

    // Map memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= map_mem[ptr_reg[AW-1:0]];
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            pool_reg      <= CNT_W'(1024);
            info_reg      <= '0;
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            fc_reg        <= '0;
            head_en_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            pool_reg      <= pool_next;
            info_reg      <= info_next;
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            fc_reg        <= fc_next;
            head_en_reg   <= head_en_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        run_reg      <= run_next;
        head_idx_reg <= head_idx_next;
        status_reg   <= status_next;
        ff_reg       <= ff_next;
        rsp_reg      <= rsp_next;
    end

endmodule

>>> design/cfa_checker.sv
module cfa_checker
    import cfa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input cfa_rsp_t rsp
);

    // One request at a time: the block stalls right after a transfer.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request side not stalled after a request transfer");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed or dropped");

    // Only a successful request may carry a nonzero first frame.
    a_first_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != RS_OK) |-> (rsp.first_frame == '0))
        else $error("failed request returned a first frame");

    // A response appears only while the block is between requests.
    a_rsp_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_stall)
        else $error("response raised while a request is still in work");

endmodule

bind contiguous_frame_allocator_unit cfa_checker u_cfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> dv/tb_top.sv
module tb_top;
    import cfa_pkg::*;

    localparam int MAP_DEPTH     = MAX_FRAMES_DEF;
    localparam int WAIT_MAX      = 18;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam longint RUN_LIMIT = 64'd60_000_000;

    // Clock, reset and the block's ports.
    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid;
    logic               req_stall;
    cfa_req_t           req;
    logic               rsp_valid;
    logic               rsp_stall;
    cfa_rsp_t           rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow copy of the frame map, the free counter and the registers.
    logic [1:0]         frame_map [MAP_DEPTH];
    logic [CNT_W-1:0]   free_total;
    logic [FRAME_W-1:0] cfg_base;
    logic [CNT_W-1:0]   cfg_pool;
    logic [FRAME_W-1:0] cfg_info;

    // Responses predicted for accepted requests, oldest first.
    cfa_rsp_t           awaited_rsp [$];
    cfa_rsp_t           next_rsp;
    int                 mismatches    = 0;
    bit                 steady        = 1'b0;
    int                 hold_request  = 0;

    always #5 clk = ~clk;

    contiguous_frame_allocator_unit #(
        .MAX_FRAMES (MAP_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Count a mismatch and tell whether it is still among the reported ones.
    function automatic bit note_mismatch();
        mismatches++;
        return mismatches <= MAX_REPORTS;
    endfunction

    // Effective pool size; register values above the map depth are clamped.
    function automatic int unsigned pool_len();
        return (cfg_pool > MAP_DEPTH) ? MAP_DEPTH : int'(cfg_pool);
    endfunction

    // The free counter saturates at zero going down.
    function automatic void take_free(input int unsigned k);
        if (k >= free_total)
            free_total = '0;
        else
            free_total = free_total - k[CNT_W-1:0];
    endfunction

    // The free counter saturates at its all-ones value going up.
    function automatic void give_free();
        if (free_total != CNT_MAX)
            free_total = free_total + 1'b1;
    endfunction

    function automatic void claim_frames(input int unsigned start, input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
            frame_map[start + i] = (i == 0) ? FS_HEAD : FS_ALLOC;
    endfunction

    // Apply one request to the shadow map and return the response it gives.
    function automatic cfa_rsp_t serve_request(input cfa_req_t r);
        cfa_rsp_t    res;
        int unsigned n;
        int unsigned fno;
        int unsigned cnt;
        int unsigned info_abs;
        int unsigned run;
        int unsigned start;
        int unsigned rel;
        int unsigned was_free;
        int unsigned i;
        bit          found;
        res = '0;
        res.status = RS_OK;
        n = pool_len();
        fno = 32'(r.frame_no);
        cnt = 32'(r.count);
        case (r.req_type)
            REQ_INIT:
            begin
                info_abs = 32'((cfg_info == '0) ? cfg_base : cfg_info);
                foreach (frame_map[k])
                    frame_map[k] = FS_FREE;
                free_total = n[CNT_W-1:0];
                if (info_abs >= cfg_base && info_abs - cfg_base < n)
                begin
                    frame_map[info_abs - cfg_base] = FS_HEAD;
                    take_free(1);
                end
            end
            REQ_ALLOC:
            begin
                // First fit: lowest run of cnt free frames.
                found = 1'b0;
                run = 0;
                start = 0;
                if (cnt != 0 && cnt <= n)
                begin
                    for (i = 0; i < n && !found; i++)
                    begin
                        if (frame_map[i] == FS_FREE)
                        begin
                            run++;
                            if (run == cnt)
                            begin
                                start = i + 1 - cnt;
                                found = 1'b1;
                            end
                        end
                        else
                            run = 0;
                    end
                end
                if (found)
                begin
                    claim_frames(start, cnt);
                    take_free(cnt);
                    res.first_frame = FRAME_W'(cfg_base + start);
                end
                else
                    res.status = RS_NOFIT;
            end
            REQ_MARK:
            begin
                if (cnt == 0)
                    res.status = RS_NOFIT;
                else if (fno < cfg_base || fno - cfg_base > n || cnt > n - (fno - cfg_base))
                    res.status = RS_RANGE;
                else
                begin
                    // Only frames that were free lower the counter.
                    rel = fno - cfg_base;
                    was_free = 0;
                    for (i = 0; i < cnt; i++)
                        if (frame_map[rel + i] == FS_FREE)
                            was_free++;
                    claim_frames(rel, cnt);
                    take_free(was_free);
                end
            end
            default:
            begin
                if (fno < cfg_base || fno - cfg_base >= n)
                    res.status = RS_RANGE;
                else
                begin
                    rel = fno - cfg_base;
                    if (frame_map[rel] != FS_HEAD)
                        res.status = RS_NOT_HEAD;
                    else
                    begin
                        // Free the head, then the allocated frames behind it.
                        frame_map[rel] = FS_FREE;
                        give_free();
                        for (i = rel + 1; i < n; i++)
                        begin
                            if (frame_map[i] != FS_ALLOC)
                                break;
                            frame_map[i] = FS_FREE;
                            give_free();
                        end
                    end
                end
            end
        endcase
        res.free_frames = free_total;
        return res;
    endfunction

    function automatic cfa_req_t request_of(input logic [1:0] kind,
                                            input logic [FRAME_W-1:0] frame,
                                            input logic [CNT_W-1:0] cnt);
        cfa_req_t r;
        r.req_type = kind;
        r.frame_no = frame;
        r.count = cnt;
        return r;
    endfunction

    // Random request, mostly well formed against the current shadow map.
    function automatic cfa_req_t next_request();
        cfa_req_t    r;
        int unsigned n;
        int unsigned pick;
        int unsigned idx;
        int unsigned len;
        int unsigned heads [$];
        int unsigned i;
        n = pool_len();
        r.req_type = 2'($urandom_range(0, 3));
        r.frame_no = FRAME_W'($urandom);
        r.count = CNT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return r;
        if (pick < 9)
        begin
            r.req_type = REQ_INIT;
        end
        else if (pick < 50)
        begin
            r.req_type = REQ_ALLOC;
            case ($urandom_range(0, 19))
                0: r.count = '0;
                1: r.count = CNT_W'($urandom_range(n + 1, CNT_MAX));
                2: r.count = CNT_W'($urandom_range(1, (n > 1) ? n : 1));
                default: r.count = CNT_W'($urandom_range(1, (n > 8) ? n / 8 : 1));
            endcase
        end
        else if (pick < 65)
        begin
            r.req_type = REQ_MARK;
            if (n != 0)
            begin
                idx = $urandom_range(0, n - 1);
                len = $urandom_range(1, (n - idx < 8) ? n - idx : 8);
                r.frame_no = FRAME_W'(cfg_base + idx);
                r.count = CNT_W'(len);
                // Some runs poke past the pool or start below it.
                case ($urandom_range(0, 9))
                    0: r.count = CNT_W'(n - idx + $urandom_range(1, 4));
                    1: r.frame_no = cfg_base - FRAME_W'($urandom_range(1, 16));
                    default: ;
                endcase
            end
        end
        else
        begin
            r.req_type = REQ_RELEASE;
            for (i = 0; i < n; i++)
                if (frame_map[i] == FS_HEAD)
                    heads.push_back(i);
            if (heads.size() != 0 && $urandom_range(0, 3) != 0)
                r.frame_no = FRAME_W'(cfg_base + heads[$urandom_range(0, heads.size() - 1)]);
            else
                r.frame_no = FRAME_W'(cfg_base + $urandom_range(0, n + 2));
        end
        return r;
    endfunction

    // Wait drawn by either side before its next transfer.
    function automatic int draw_wait();
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, WAIT_MAX);
    endfunction

    // Offer one request and record its predicted response on transfer.
    task automatic send_request(input cfa_req_t item);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (req_stall);
        awaited_rsp.push_back(serve_request(item));
    endtask

    // Stop offering and wait until every predicted response has come back.
    task automatic wait_idle();
        req_valid <= 1'b0;
        do @(posedge clk); while (awaited_rsp.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup phase, then access phase until pready.
    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [PDATA_W-1:0] reg_image(input logic [1:0] idx);
        logic [PDATA_W-1:0] v;
        v = '0;
        case (idx)
            REG_BASE: v[FRAME_W-1:0] = cfg_base;
            REG_POOL: v[CNT_W-1:0] = cfg_pool;
            default:  v[FRAME_W-1:0] = cfg_info;
        endcase
        return v;
    endfunction

    // Write a register, update the shadow copy and read the value back.
    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] word);
        logic [PDATA_W-1:0] back;
        apb_access(idx, 1'b1, word, back);
        case (idx)
            REG_BASE: cfg_base = word[FRAME_W-1:0];
            REG_POOL: cfg_pool = word[CNT_W-1:0];
            default:  cfg_info = word[FRAME_W-1:0];
        endcase
        apb_access(idx, 1'b0, '0, back);
        if (back !== reg_image(idx))
            if (note_mismatch())
                $display("register %0d readback: expected %h, got %h",
                         idx, reg_image(idx), back);
    endtask

    // Reprogram all three registers while the block is idle.
    task automatic configure(input logic [FRAME_W-1:0] base, input logic [CNT_W-1:0] pool,
                             input logic [FRAME_W-1:0] info);
        logic [PDATA_W-1:0] word;
        wait_idle();
        word = $urandom;
        word[FRAME_W-1:0] = base;
        write_reg(REG_BASE, word);
        word = $urandom;
        word[CNT_W-1:0] = pool;
        write_reg(REG_POOL, word);
        word = $urandom;
        word[FRAME_W-1:0] = info;
        write_reg(REG_INFO, word);
    endtask

    // Requests served on the cleared map before any init, reset registers.
    task automatic test_before_init();
        send_request(request_of(REQ_ALLOC, '0, 11'd4));
        send_request(request_of(REQ_RELEASE, '0, '0));
    endtask

    // Every request kind and its error paths on a small pool.
    task automatic test_request_kinds();
        configure(20'h00100, 11'd12, 20'h0010B);
        send_request(request_of(REQ_INIT, '0, '0));
        send_request(request_of(REQ_ALLOC, '0, 11'd0));
        send_request(request_of(REQ_ALLOC, '0, 11'd2047));
        send_request(request_of(REQ_ALLOC, '0, 11'd12));
        send_request(request_of(REQ_ALLOC, '0, 11'd3));
        send_request(request_of(REQ_ALLOC, '0, 11'd2));
        // The walk stops at the head of the second run.
        send_request(request_of(REQ_RELEASE, 20'h00100, '0));
        send_request(request_of(REQ_RELEASE, 20'h00101, '0));
        send_request(request_of(REQ_RELEASE, 20'h00104, '0));
        // Marking over a mix of free and claimed frames.
        send_request(request_of(REQ_MARK, 20'h00102, 11'd4));
        send_request(request_of(REQ_RELEASE, 20'h00102, '0));
        send_request(request_of(REQ_MARK, 20'h00102, 11'd0));
        send_request(request_of(REQ_MARK, 20'h000FF, 11'd1));
        send_request(request_of(REQ_MARK, 20'h00109, 11'd3));
        send_request(request_of(REQ_MARK, 20'h00109, 11'd4));
        send_request(request_of(REQ_RELEASE, 20'hFFFFF, '0));
        // This walk runs to the end of the pool.
        send_request(request_of(REQ_RELEASE, 20'h00109, '0));
    endtask

    // Register extremes: top of the frame space, wrap, empty and clamped pools.
    task automatic test_register_extremes();
        configure(20'hFFFFF, 11'd1, 20'h00000);
        send_request(request_of(REQ_INIT, '0, '0));
        send_request(request_of(REQ_ALLOC, '0, 11'd1));
        send_request(request_of(REQ_RELEASE, 20'hFFFFF, '0));
        send_request(request_of(REQ_ALLOC, '0, 11'd1));
        configure(20'hFFF00, 11'd2047, 20'hFFFFF);
        send_request(request_of(REQ_INIT, '0, '0));
        send_request(request_of(REQ_ALLOC, '0, 11'd512));
        send_request(request_of(REQ_ALLOC, '0, 11'd200));
        configure(20'h00040, 11'd0, 20'h00000);
        send_request(request_of(REQ_INIT, '0, '0));
        send_request(request_of(REQ_ALLOC, '0, 11'd1));
        send_request(request_of(REQ_MARK, 20'h00040, 11'd1));
        send_request(request_of(REQ_RELEASE, 20'h00040, '0));
        configure(20'h00200, 11'd8, 20'h00010);
        send_request(request_of(REQ_INIT, '0, '0));
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_hold();
        int k;
        configure(20'h00000, 11'd64, 20'h00000);
        send_request(request_of(REQ_INIT, '0, '0));
        hold_request = HOLD_CYCLES;
        steady = 1'b1;
        for (k = 0; k < 10; k++)
            send_request(request_of(REQ_ALLOC, '0, 11'd1));
        steady = 1'b0;
        wait_idle();
    endtask

    // One random phase; the sender pauses halfway until all results are in.
    task automatic run_traffic(input logic [FRAME_W-1:0] base, input logic [CNT_W-1:0] pool,
                               input logic [FRAME_W-1:0] info, input int items,
                               input bit with_init);
        int k;
        configure(base, pool, info);
        if (with_init)
            send_request(request_of(REQ_INIT, '0, '0));
        for (k = 0; k < items; k++)
        begin
            if (k % 32 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (k == items / 2)
                wait_idle();
            send_request(next_request());
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_traffic(20'h00000, 11'd1024, 20'h00000, 70, 1'b1);
        run_traffic(20'h12345, 11'd16, 20'h1234A, 80, 1'b1);
        run_traffic(FRAME_W'($urandom_range(1, 20'hF0000)), 11'd64, 20'hFFFFF, 80, 1'b1);
        run_traffic(20'hFFFD7, 11'd41, 20'h00000, 80, 1'b1);
        run_traffic(20'h80000, 11'd1500, 20'h803FF, 70, 1'b1);
        run_traffic(20'hABCDE, 11'd8, 20'hABCE0, 80, 1'b1);
        // Registers change without an init, so the old map stays in place.
        run_traffic(FRAME_W'($urandom), CNT_W'($urandom_range(1, 128)),
                    FRAME_W'($urandom), 80, 1'b0);
    endtask

    // Response side: random stalls per transfer, or a long hold on request.
    initial
    begin
        int w;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                w = hold_request;
                hold_request = 0;
            end
            else
                w = draw_wait();
            if (w > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (w) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // Compare each response transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
            begin
                if (note_mismatch())
                    $display("unexpected result: first_frame=%h status=%0d free=%0d",
                             rsp.first_frame, rsp.status, rsp.free_frames);
            end
            else
            begin
                next_rsp = awaited_rsp.pop_front();
                if (rsp.first_frame !== next_rsp.first_frame ||
                    rsp.status !== next_rsp.status ||
                    rsp.free_frames !== next_rsp.free_frames)
                    if (note_mismatch())
                        $display("result mismatch: expected first_frame=%h status=%0d free=%0d, %s",
                                 next_rsp.first_frame, next_rsp.status, next_rsp.free_frames,
                                 $sformatf("got first_frame=%h status=%0d free=%0d",
                                           rsp.first_frame, rsp.status, rsp.free_frames));
            end
        end
    end

    // Run limit.
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", awaited_rsp.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Main sequence.
    initial
    begin
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_base = '0;
        cfg_pool = 11'd1024;
        cfg_info = '0;
        free_total = '0;
        foreach (frame_map[k])
            frame_map[k] = FS_FREE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_request_kinds();
        test_register_extremes();
        test_output_hold();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
